/* rtl/lfsm_pkg.sv */
// ----------------------------------------------------------------------------
// lfsm_pkg: shared types and constants for the latest frame slot manager
// Slot pool size, op and status codes, item and result words.
// ----------------------------------------------------------------------------
package lfsm_pkg;

  localparam int unsigned SLOT_COUNT = 4;  // 2 .. 8
  localparam int unsigned SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_DECIMATED = 3'd0,
    ST_PUBLISHED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_ACQUIRED  = 3'd3,
    ST_NONE      = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_IGNORED   = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  frame_id;
    logic [31:0] last_seen_seq;
    logic [2:0]  release_slot;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot_index;
    logic [31:0] sequence_res;
    logic [7:0]  granted_frame;
    logic        give_back_valid;
    logic [7:0]  give_back_frame;
  } res_t;

endpackage

/* rtl/lfsm_in_if.sv */
// ----------------------------------------------------------------------------
// lfsm_in_if: request channel of the latest frame slot manager
// Valid/ready handshake carrying one op word.
// ----------------------------------------------------------------------------
interface lfsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  frame_id;
  logic [31:0] last_seen_seq;
  logic [2:0]  release_slot;

  modport source (output valid, output op, output frame_id, output last_seen_seq,
                  output release_slot, input ready);
  modport sink   (input valid, input op, input frame_id, input last_seen_seq,
                  input release_slot, output ready);
endinterface

/* rtl/lfsm_out_if.sv */
// ----------------------------------------------------------------------------
// lfsm_out_if: result channel of the latest frame slot manager
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface lfsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot_index;
  logic [31:0] sequence_res;
  logic [7:0]  granted_frame;
  logic        give_back_valid;
  logic [7:0]  give_back_frame;

  modport source (output valid, output status, output slot_index, output sequence_res,
                  output granted_frame, output give_back_valid, output give_back_frame,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input sequence_res,
                  input granted_frame, input give_back_valid, input give_back_frame,
                  output ready);
endinterface

/* rtl/lfsm_core.sv */
// ----------------------------------------------------------------------------
// lfsm_core: slot pool state and per-request op update
// Holds reference counts, buffer handles and newest-frame tracking.
// ----------------------------------------------------------------------------
module lfsm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            proc_i,
  input  lfsm_pkg::item_t item_i,
  input  logic [7:0]      frame_divisor_i,
  output lfsm_pkg::res_t  res_o
);

  localparam int unsigned IW = lfsm_pkg::SLOT_IDX_W;

  logic [7:0]    cnt_q [lfsm_pkg::SLOT_COUNT];
  logic [7:0]    cnt_d [lfsm_pkg::SLOT_COUNT];
  logic [7:0]    buf_q [lfsm_pkg::SLOT_COUNT];
  logic          newest_vld_q, newest_vld_d;
  logic [IW-1:0] newest_slot_q, newest_slot_d;
  logic [31:0]   newest_seq_q, newest_seq_d;
  logic [31:0]   seq_q, seq_d;
  logic [7:0]    phase_q, phase_d;

  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          rel_ok;
  logic [IW-1:0] rel_idx;
  logic [IW-1:0] rd_idx;
  logic [7:0]    rd_cnt;
  logic [7:0]    rd_buf;
  logic [7:0]    div;
  logic [8:0]    phase_nxt;
  logic          buf_we;

  // first slot with zero count
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = lfsm_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (cnt_q[i] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign rel_ok  = ({1'b0, item_i.release_slot} < 4'(lfsm_pkg::SLOT_COUNT));
  assign rel_idx = item_i.release_slot[IW-1:0];

  // one shared read port: release slot or newest slot
  assign rd_idx = (item_i.op == lfsm_pkg::OP_RELEASE) ? rel_idx : newest_slot_q;
  assign rd_cnt = cnt_q[rd_idx];
  assign rd_buf = buf_q[rd_idx];

  assign div       = (frame_divisor_i == 8'd0) ? 8'd1 : frame_divisor_i;
  assign phase_nxt = {1'b0, phase_q} + 9'd1;

  always_comb begin
    cnt_d         = cnt_q;
    newest_vld_d  = newest_vld_q;
    newest_slot_d = newest_slot_q;
    newest_seq_d  = newest_seq_q;
    seq_d         = seq_q;
    phase_d       = phase_q;
    buf_we        = 1'b0;
    res_o         = '0;
    res_o.status  = lfsm_pkg::ST_IGNORED;

    case (item_i.op)
      lfsm_pkg::OP_CAPTURE: begin
        if (phase_nxt < {1'b0, div}) begin
          phase_d               = phase_nxt[7:0];
          res_o.status          = lfsm_pkg::ST_DECIMATED;
          res_o.give_back_valid = 1'b1;
          res_o.give_back_frame = item_i.frame_id;
        end else begin
          phase_d = 8'd0;
          if (!free_found) begin
            res_o.status          = lfsm_pkg::ST_DROPPED;
            res_o.give_back_valid = 1'b1;
            res_o.give_back_frame = item_i.frame_id;
          end else begin
            // drop the producer reference on the previous newest frame
            if (newest_vld_q && newest_slot_q != free_idx && rd_cnt != 8'd0) begin
              cnt_d[newest_slot_q] = rd_cnt - 8'd1;
              if (rd_cnt == 8'd1) begin
                res_o.give_back_valid = 1'b1;
                res_o.give_back_frame = rd_buf;
              end
            end
            buf_we             = 1'b1;
            cnt_d[free_idx]    = 8'd1;
            seq_d              = seq_q + 32'd1;
            newest_seq_d       = seq_q + 32'd1;
            newest_slot_d      = free_idx;
            newest_vld_d       = 1'b1;
            res_o.status       = lfsm_pkg::ST_PUBLISHED;
            res_o.slot_index   = 3'(free_idx);
            res_o.sequence_res = seq_q + 32'd1;
          end
        end
      end
      lfsm_pkg::OP_ACQUIRE: begin
        if (newest_vld_q && newest_seq_q != item_i.last_seen_seq &&
            rd_cnt != 8'd0 && rd_cnt != lfsm_pkg::COUNT_MAX) begin
          cnt_d[newest_slot_q] = rd_cnt + 8'd1;
          res_o.status         = lfsm_pkg::ST_ACQUIRED;
          res_o.slot_index     = 3'(newest_slot_q);
          res_o.sequence_res   = newest_seq_q;
          res_o.granted_frame  = rd_buf;
        end else begin
          res_o.status = lfsm_pkg::ST_NONE;
        end
      end
      lfsm_pkg::OP_RELEASE: begin
        res_o.slot_index = item_i.release_slot;
        if (!rel_ok || rd_cnt == 8'd0) begin
          res_o.status = lfsm_pkg::ST_IGNORED;
        end else begin
          cnt_d[rel_idx] = rd_cnt - 8'd1;
          res_o.status   = lfsm_pkg::ST_RELEASED;
          if (rd_cnt == 8'd1) begin
            res_o.give_back_valid = 1'b1;
            res_o.give_back_frame = rd_buf;
          end
        end
      end
      default: begin
        res_o.status = lfsm_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lfsm_pkg::SLOT_COUNT; i++) begin
        cnt_q[i] <= 8'd0;
      end
      newest_vld_q  <= 1'b0;
      newest_slot_q <= '0;
      newest_seq_q  <= 32'd0;
      seq_q         <= 32'd0;
      phase_q       <= 8'd0;
    end else if (proc_i) begin
      cnt_q         <= cnt_d;
      newest_vld_q  <= newest_vld_d;
      newest_slot_q <= newest_slot_d;
      newest_seq_q  <= newest_seq_d;
      seq_q         <= seq_d;
      phase_q       <= phase_d;
    end
  end

  // buffer handles: only read behind a nonzero count, so no reset
  always_ff @(posedge clk_i) begin
    if (proc_i && buf_we) begin
      buf_q[free_idx] <= item_i.frame_id;
    end
  end

endmodule

/* rtl/latest_frame_slot_manager.sv */
// ----------------------------------------------------------------------------
// latest_frame_slot_manager: reference-counted pool publishing the newest frame
// Top level: request register, slot pool update stage, result register.
// ----------------------------------------------------------------------------
// Usage: one request word (capture, acquire or release) is taken per clock
// when the result side keeps up; the result word passes through the request
// register and the result register after the request is accepted. The pool
// update stage reads the slot counts, finds the first free slot and writes
// the new counts as one update, so back-to-back requests see each other's
// effects in order. A stalled result holds in the result register while one
// more request waits in the request register. The frame divisor may only be
// written while no request is in flight; it resets to 1, and 0 behaves as 1.
module latest_frame_slot_manager (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  lfsm_in_if.sink    in_i,
  lfsm_out_if.source res_o
);

  logic            in_vld_q;
  lfsm_pkg::item_t in_q;
  logic            res_vld_q;
  lfsm_pkg::res_t  res_q;
  lfsm_pkg::res_t  core_res;
  logic [7:0]      frame_divisor_q;
  logic            res_free;
  logic            proc;
  logic            in_fire;

  // result register can take a word this cycle
  assign res_free = !res_vld_q || res_o.ready;
  // request in the input register goes through the pool update now
  assign proc     = in_vld_q && res_free;

  assign in_i.ready = !in_vld_q || res_free;
  assign in_fire    = in_i.valid && in_i.ready;

  // frame divisor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_divisor_q <= 8'd1;
    end else if (cfg_we_i) begin
      frame_divisor_q <= cfg_wdata_i;
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.op            <= in_i.op;
      in_q.frame_id      <= in_i.frame_id;
      in_q.last_seen_seq <= in_i.last_seen_seq;
      in_q.release_slot  <= in_i.release_slot;
    end
  end

  // pool state and update
  lfsm_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .proc_i          (proc),
    .item_i          (in_q),
    .frame_divisor_i (frame_divisor_q),
    .res_o           (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (proc) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid           = res_vld_q;
  assign res_o.status          = res_q.status;
  assign res_o.slot_index      = res_q.slot_index;
  assign res_o.sequence_res    = res_q.sequence_res;
  assign res_o.granted_frame   = res_q.granted_frame;
  assign res_o.give_back_valid = res_q.give_back_valid;
  assign res_o.give_back_frame = res_q.give_back_frame;

  // back-pressure only when both stages hold words and the sink stalls
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && res_vld_q && !res_o.ready))
    else $error("request side stalled with a free stage");

  // every processed request lands in the result register
  a_proc_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> res_vld_q)
    else $error("processed request produced no result");

  // an accepted request is in the input register next cycle
  a_fire_to_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_vld_q)
    else $error("accepted request lost");

endmodule

/* sim/slot_pool_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_checker: result checker for the latest frame slot manager
// Tracks slot reference counts, publish order and decimation from the request
// and config traffic, and compares every result word with its prediction.
// ----------------------------------------------------------------------------
module slot_pool_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  lfsm_in_if          req_i,
  lfsm_out_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned backlog_o
);

  localparam int unsigned REPORT_MAX = 10;

  // shadow of the pool
  logic [7:0]  divisor;
  logic [7:0]  pool_refs  [lfsm_pkg::SLOT_COUNT];
  logic [7:0]  pool_frame [lfsm_pkg::SLOT_COUNT];
  logic        latest_live;
  logic [2:0]  latest_slot;
  logic [31:0] latest_seq;
  logic [31:0] seq_next;
  logic [7:0]  skip_count;

  lfsm_pkg::res_t  answers_due [$];
  lfsm_pkg::res_t  want;
  lfsm_pkg::res_t  got;
  lfsm_pkg::item_t word;
  int unsigned     answer_no;

  function automatic lfsm_pkg::res_t predict_answer(input lfsm_pkg::item_t w);
    lfsm_pkg::res_t r;
    int             free_slot;
    logic [7:0]     div_eff;
    logic [8:0]     next_skip;
    r = '0;
    case (w.op)
      lfsm_pkg::OP_CAPTURE: begin
        div_eff   = (divisor == 8'd0) ? 8'd1 : divisor;
        next_skip = {1'b0, skip_count} + 9'd1;
        if (next_skip < {1'b0, div_eff}) begin
          skip_count        = next_skip[7:0];
          r.status          = lfsm_pkg::ST_DECIMATED;
          r.give_back_valid = 1'b1;
          r.give_back_frame = w.frame_id;
        end else begin
          skip_count = '0;
          free_slot  = -1;
          for (int i = lfsm_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (pool_refs[i] == 8'd0) free_slot = i;
          end
          if (free_slot < 0) begin
            r.status          = lfsm_pkg::ST_DROPPED;
            r.give_back_valid = 1'b1;
            r.give_back_frame = w.frame_id;
          end else begin
            // producer reference moves from the old newest frame to the new one
            if (latest_live && latest_slot != free_slot[2:0] &&
                pool_refs[latest_slot] != 8'd0) begin
              pool_refs[latest_slot] = pool_refs[latest_slot] - 8'd1;
              if (pool_refs[latest_slot] == 8'd0) begin
                r.give_back_valid = 1'b1;
                r.give_back_frame = pool_frame[latest_slot];
              end
            end
            pool_frame[free_slot] = w.frame_id;
            pool_refs[free_slot]  = 8'd1;
            seq_next              = seq_next + 32'd1;
            latest_seq            = seq_next;
            latest_slot           = free_slot[2:0];
            latest_live           = 1'b1;
            r.status              = lfsm_pkg::ST_PUBLISHED;
            r.slot_index          = free_slot[2:0];
            r.sequence_res        = latest_seq;
          end
        end
      end
      lfsm_pkg::OP_ACQUIRE: begin
        r.status = lfsm_pkg::ST_NONE;
        if (latest_live && latest_seq != w.last_seen_seq &&
            latest_slot < lfsm_pkg::SLOT_COUNT) begin
          if (pool_refs[latest_slot] != 8'd0 &&
              pool_refs[latest_slot] != lfsm_pkg::COUNT_MAX) begin
            pool_refs[latest_slot] = pool_refs[latest_slot] + 8'd1;
            r.status        = lfsm_pkg::ST_ACQUIRED;
            r.slot_index    = latest_slot;
            r.sequence_res  = latest_seq;
            r.granted_frame = pool_frame[latest_slot];
          end
        end
      end
      lfsm_pkg::OP_RELEASE: begin
        r.slot_index = w.release_slot;
        r.status     = lfsm_pkg::ST_IGNORED;
        if (w.release_slot < lfsm_pkg::SLOT_COUNT) begin
          if (pool_refs[w.release_slot] != 8'd0) begin
            pool_refs[w.release_slot] = pool_refs[w.release_slot] - 8'd1;
            r.status = lfsm_pkg::ST_RELEASED;
            if (pool_refs[w.release_slot] == 8'd0) begin
              r.give_back_valid = 1'b1;
              r.give_back_frame = pool_frame[w.release_slot];
            end
          end
        end
      end
      default: r.status = lfsm_pkg::ST_IGNORED;
    endcase
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_MAX) $display("%t ERROR %s", $realtime, msg);
  endtask

  initial begin
    fail_count_o = 0;
    backlog_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor     = 8'd1;
      latest_live = 1'b0;
      latest_slot = '0;
      latest_seq  = '0;
      seq_next    = '0;
      skip_count  = '0;
      answer_no   = 0;
      for (int i = 0; i < lfsm_pkg::SLOT_COUNT; i++) begin
        pool_refs[i]  = '0;
        pool_frame[i] = '0;
      end
      answers_due.delete();
      backlog_o = 0;
    end else begin
      if (cfg_we_i) divisor = cfg_wdata_i;

      // results first: a word returned this edge belongs to an older request
      if (res_i.valid && res_i.ready) begin
        got.status          = lfsm_pkg::status_e'(res_i.status);
        got.slot_index      = res_i.slot_index;
        got.sequence_res    = res_i.sequence_res;
        got.granted_frame   = res_i.granted_frame;
        got.give_back_valid = res_i.give_back_valid;
        got.give_back_frame = res_i.give_back_frame;
        if (answers_due.size() == 0) begin
          note_failure($sformatf("unexpected result word st=%0d slot=%0d seq=%h",
                                 got.status, got.slot_index, got.sequence_res));
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.slot_index !== want.slot_index ||
              got.sequence_res !== want.sequence_res ||
              got.granted_frame !== want.granted_frame ||
              got.give_back_valid !== want.give_back_valid ||
              got.give_back_frame !== want.give_back_frame) begin
            note_failure($sformatf({"word %0d: expected st=%0d slot=%0d seq=%h grant=%h ",
                                    "back=%b/%h, got st=%0d slot=%0d seq=%h grant=%h ",
                                    "back=%b/%h"}, answer_no,
                                   want.status, want.slot_index, want.sequence_res,
                                   want.granted_frame, want.give_back_valid,
                                   want.give_back_frame, got.status, got.slot_index,
                                   got.sequence_res, got.granted_frame,
                                   got.give_back_valid, got.give_back_frame));
          end
        end
        answer_no++;
      end

      if (req_i.valid && req_i.ready) begin
        word.op            = req_i.op;
        word.frame_id      = req_i.frame_id;
        word.last_seen_seq = req_i.last_seen_seq;
        word.release_slot  = req_i.release_slot;
        answers_due.push_back(predict_answer(word));
      end
      backlog_o = answers_due.size();
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top of the latest frame slot manager simulation
// Drives capture, acquire and release words with bursty flow on both sides,
// sweeps the frame divisor, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  // op code with no meaning to the block, answered as ignored
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam int unsigned PHASE_WORDS = 25;   // random words per divisor setting
  localparam int unsigned HOLD_CYCLES = 90;   // long result-side hold-off
  localparam int unsigned STALL_LIMIT = 3000; // cycles with no handshake at all
  localparam int unsigned SATURATE    = 256;  // acquires to pin one slot at 255

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  int unsigned fails;
  int unsigned answers_due;

  // consumer view, learned from the result channel
  logic [2:0]  held_slots [$];
  logic [31:0] seen_seq;
  logic [31:0] newest_guess;

  int unsigned burst_left;
  int unsigned hold_asks;
  int unsigned hold_served;
  int unsigned idle_cycles;

  lfsm_in_if  in_ch ();
  lfsm_out_if res_ch ();

  latest_frame_slot_manager dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .res_o       (res_ch)
  );

  slot_pool_checker pool_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (in_ch),
    .res_i        (res_ch),
    .fail_count_o (fails),
    .backlog_o    (answers_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Word building. Fields an op does not use carry random values so every
  // bit of every field toggles; the one field the op reads comes from arg.
  // --------------------------------------------------------------------------
  function automatic lfsm_pkg::item_t word_of(input logic [1:0] op, input logic [31:0] arg);
    lfsm_pkg::item_t w;
    w.op            = op;
    w.frame_id      = 8'($urandom);
    w.last_seen_seq = $urandom;
    w.release_slot  = 3'($urandom);
    case (op)
      lfsm_pkg::OP_CAPTURE: w.frame_id      = arg[7:0];
      lfsm_pkg::OP_ACQUIRE: w.last_seen_seq = arg;
      lfsm_pkg::OP_RELEASE: w.release_slot  = arg[2:0];
      default: ;
    endcase
    return w;
  endfunction

  // Mostly a well-behaved consumer: acquire with the sequence it last got,
  // release slots it actually holds. The rest is noise: stale or random
  // sequence numbers, releases of idle or out-of-range slots, unknown ops.
  function automatic lfsm_pkg::item_t random_word();
    int unsigned pick;
    int unsigned roll;
    int unsigned idx;
    logic [1:0]  op;
    logic [31:0] arg;
    pick = $urandom_range(99);
    roll = $urandom_range(9);
    arg  = $urandom;
    if (pick < 35) begin
      op = lfsm_pkg::OP_CAPTURE;
    end else if (pick < 65) begin
      op = lfsm_pkg::OP_ACQUIRE;
      if (roll < 4) arg = seen_seq;
      else if (roll < 6) arg = newest_guess;
    end else if (pick < 95) begin
      op = lfsm_pkg::OP_RELEASE;
      if (roll < 5 && held_slots.size() != 0) begin
        idx = $urandom_range(held_slots.size() - 1);
        arg = 32'(held_slots[idx]);
        held_slots.delete(idx);
      end else if (roll < 8) begin
        arg = $urandom_range(lfsm_pkg::SLOT_COUNT - 1);
      end else begin
        arg = $urandom_range(7);
      end
    end else begin
      op = OP_UNKNOWN;
    end
    return word_of(op, arg);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Words go out in bursts; between bursts valid drops for a
  // random gap, and about a quarter of bursts follow with no gap at all.
  // Inputs change on the falling edge, ready is sampled on the rising edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input lfsm_pkg::item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.op            = w.op;
    in_ch.frame_id      = w.frame_id;
    in_ch.last_seen_seq = w.last_seen_seq;
    in_ch.release_slot  = w.release_slot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drain: stop offering, wait for every predicted word, then let the clock run
  // on so the two-stage pipe is surely empty.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (answers_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_divisor(input logic [7:0] value);
    settle();
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // consumer bookkeeping: which slots we hold and the last sequence seen
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      if (res_ch.status == lfsm_pkg::ST_ACQUIRED) begin
        seen_seq = res_ch.sequence_res;
        held_slots.push_back(res_ch.slot_index);
      end
      if (res_ch.status == lfsm_pkg::ST_PUBLISHED) newest_guess = res_ch.sequence_res;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. Ready follows an 8-bit pattern that changes every segment;
  // all-ones segments give stretches with no stall. On request from the
  // stimulus it holds ready low for a long stretch so the block backs up.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  pattern;
    int unsigned span;
    res_ch.ready = 1'b0;
    hold_served  = 0;
    wait (rst_n);
    forever begin
      if (hold_asks > hold_served) begin
        repeat ($urandom_range(5, 20)) @(negedge clk);
        @(negedge clk);
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end
      pattern = ($urandom_range(2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      span    = $urandom_range(8, 64);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        res_ch.ready = pattern[k % 8];
      end
    end
  end

  // watchdog: any handshake on either side counts as progress
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] plan [6];
    in_ch.valid         = 1'b0;
    in_ch.op            = '0;
    in_ch.frame_id      = '0;
    in_ch.last_seen_seq = '0;
    in_ch.release_slot  = '0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    seen_seq            = '0;
    newest_guess        = '0;
    burst_left          = 0;
    hold_asks           = 0;
    rst_n               = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass, divisor still at its reset value of 1.
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'h0));   // nothing ever published
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd0));   // idle slot
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd7));   // slot index out of range
    send_word(word_of(OP_UNKNOWN, 32'h0));
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'h00));  // slot 0, seq 1
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'd1));   // already seen
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'd0));   // granted, count 2
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd0));
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd0));   // count 0, buffer returned
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'd0));   // newest slot went idle
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'hFF));  // reuses the newest slot
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'hFFFF_FFFF));
    // capture + acquire pins each slot in turn until the pool is full
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'h5A));
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'h0));
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'hA5));
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'h0));
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'h3C));
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, 32'h0));
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'hC3));  // no free slot, dropped
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd3));
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd4));   // just past the pool
    send_word(word_of(lfsm_pkg::OP_RELEASE, 32'd3));   // newest slot back to zero
    send_word(word_of(lfsm_pkg::OP_CAPTURE, 32'h81));  // lands in that same slot

    // Random traffic over a sweep of divisors. 255 only decimates; dropping
    // to 2 right after leaves the phase above the divisor, so the next
    // capture is kept at once. 0 must behave as 1.
    plan    = '{8'd0, 8'd3, 8'd255, 8'd2, 8'd0, 8'd1};
    plan[4] = 8'($urandom_range(4, 9));
    foreach (plan[p]) begin
      write_divisor(plan[p]);
      if (p == 0 || p == 3) hold_asks++;
      repeat (PHASE_WORDS) send_word(random_word());
    end

    // Count saturation: hand back everything held so a slot is free, publish
    // one frame and keep acquiring it until acquire is refused at 255.
    settle();
    while (held_slots.size() != 0) begin
      send_word(word_of(lfsm_pkg::OP_RELEASE, 32'(held_slots.pop_front())));
    end
    send_word(word_of(lfsm_pkg::OP_CAPTURE, $urandom));
    repeat (SATURATE) send_word(word_of(lfsm_pkg::OP_ACQUIRE, $urandom | 32'h8000_0000));
    repeat (3) begin
      if (held_slots.size() != 0) begin
        send_word(word_of(lfsm_pkg::OP_RELEASE, 32'(held_slots.pop_front())));
      end
    end
    send_word(word_of(lfsm_pkg::OP_ACQUIRE, $urandom | 32'h8000_0000));

    settle();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* latest_frame_slot_manager.f */
rtl/lfsm_pkg.sv
rtl/lfsm_in_if.sv
rtl/lfsm_out_if.sv
rtl/lfsm_core.sv
rtl/latest_frame_slot_manager.sv
sim/slot_pool_checker.sv
sim/testbench.sv
